// ----- rtl/core/stepper_move_sequencer_unit_defines.svh -----
// Assertion macros shared by the stepper move sequencer RTL
`ifndef STEPPER_MOVE_SEQUENCER_UNIT_DEFINES_SVH
`define STEPPER_MOVE_SEQUENCER_UNIT_DEFINES_SVH

// Plain property, checked on every rising clk edge outside reset
`define SMSEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, checked on every rising clk edge outside reset
`define SMSEQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset
`define SMSEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/smseq_pkg.sv -----
// Package: types, constants and coil table of the stepper move sequencer
package smseq_pkg;

    localparam int INTERVAL_W = 24;
    localparam int POS_W      = 16;
    localparam int MOVE_W     = 16;
    localparam int COIL_W     = 4;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd183;
    localparam logic [POS_W-1:0]      REV_RESET      = 16'd2048;
    localparam logic [INTERVAL_W-1:0] TICK_MAX       = 24'hFF_FFFF;
    localparam logic [1:0]            PHASE_MASK     = 2'b11;

    localparam logic [COIL_W-1:0] COIL_PHASE0 = 4'd5;
    localparam logic [COIL_W-1:0] COIL_PHASE1 = 4'd6;
    localparam logic [COIL_W-1:0] COIL_PHASE2 = 4'd10;
    localparam logic [COIL_W-1:0] COIL_PHASE3 = 4'd9;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_MOVE = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        CFG_STEP_INTERVAL = 1'b0,
        CFG_STEPS_PER_REV = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] step_interval;
        logic [POS_W-1:0]      steps_per_rev;
    } cfg_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [MOVE_W-1:0]  move_steps;
    } in_item_t;

    typedef struct packed {
        logic [COIL_W-1:0] coil_pattern;
        logic [POS_W-1:0]  position;
        logic              stepped;
        logic              busy_res;
        logic              rejected;
    } out_item_t;

    function automatic logic [COIL_W-1:0] coil_for_phase(input logic [1:0] phase);
        logic [COIL_W-1:0] coil;
        unique case (phase & PHASE_MASK)
            2'd0:    coil = COIL_PHASE0;
            2'd1:    coil = COIL_PHASE1;
            2'd2:    coil = COIL_PHASE2;
            default: coil = COIL_PHASE3;
        endcase
        return coil;
    endfunction

endpackage

// ----- rtl/core/smseq_ifs.sv -----
// Valid/ready channel interfaces for sequencer items and results
interface smseq_in_if;
    import smseq_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface smseq_out_if;
    import smseq_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/smseq_cfg_regs.sv -----
// Configuration registers: step interval and steps per revolution
module smseq_cfg_regs (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  smseq_pkg::cfg_index_t                   cfg_index,
    input  logic [smseq_pkg::INTERVAL_W-1:0]        cfg_data,
    output smseq_pkg::cfg_t                         cfg
);
    import smseq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_INTERVAL: cfg_next.step_interval = cfg_data;
                CFG_STEPS_PER_REV: cfg_next.steps_per_rev = cfg_data[POS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_interval <= INTERVAL_RESET;
            cfg_reg.steps_per_rev <= REV_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/smseq_step_core.sv -----
// Step core: move loading, tick counting, position wrap and coil phase
`include "stepper_move_sequencer_unit_defines.svh"
module smseq_step_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smseq_pkg::cfg_t       cfg,
    input  logic                  accept,
    input  smseq_pkg::in_item_t   item,
    output smseq_pkg::out_item_t  result
);
    import smseq_pkg::*;

    localparam int MW = (COUNT_WIDTH > MOVE_W) ? COUNT_WIDTH : MOVE_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] steps_reg,   steps_next;
    logic                   forward_reg, forward_next;
    logic [POS_W-1:0]       pos_reg,     pos_next;
    logic [INTERVAL_W-1:0]  elapsed_reg, elapsed_next;
    logic [COIL_W-1:0]      coil_reg,    coil_next;

    logic                   busy;
    logic [MOVE_W-1:0]      raw;
    logic [MOVE_W-1:0]      mag;
    logic [MW-1:0]          mag_ext;
    logic [COUNT_WIDTH-1:0] load_count;
    logic [INTERVAL_W-1:0]  elapsed_inc;
    logic [POS_W-1:0]       fwd_base;
    logic [POS_W-1:0]       bwd_base;
    logic [POS_W-1:0]       step_pos;
    logic                   step_fire;
    logic                   rejected;

    always_comb
    begin
        busy        = (steps_reg != '0);
        raw         = unsigned'(item.move_steps);
        mag         = raw[MOVE_W-1] ? (~raw + MOVE_W'(1)) : raw;
        mag_ext     = MW'(mag);
        load_count  = (mag_ext > MW'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(mag_ext);
        elapsed_inc = (elapsed_reg != TICK_MAX) ? (elapsed_reg + INTERVAL_W'(1))
                                                : elapsed_reg;
        fwd_base    = (pos_reg >= cfg.steps_per_rev) ? '0 : pos_reg;
        bwd_base    = ((pos_reg == '0) || (pos_reg > cfg.steps_per_rev))
                      ? cfg.steps_per_rev : pos_reg;
        step_pos    = forward_reg ? (fwd_base + POS_W'(1)) : (bwd_base - POS_W'(1));

        steps_next   = steps_reg;
        forward_next = forward_reg;
        pos_next     = pos_reg;
        elapsed_next = elapsed_reg;
        coil_next    = coil_reg;
        step_fire    = 1'b0;
        rejected     = 1'b0;

        if (accept)
        begin
            if (item.opcode == OP_MOVE)
            begin
                if (busy)
                begin
                    rejected = 1'b1;
                end
                else if (raw != '0)
                begin
                    forward_next = !raw[MOVE_W-1];
                    steps_next   = load_count;
                end
            end
            else if (busy)
            begin
                if (elapsed_inc >= cfg.step_interval)
                begin
                    elapsed_next = '0;
                    pos_next     = step_pos;
                    coil_next    = coil_for_phase(step_pos[1:0]);
                    steps_next   = steps_reg - COUNT_WIDTH'(1);
                    step_fire    = 1'b1;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
        end

        result.coil_pattern = coil_next;
        result.position     = pos_next;
        result.stepped      = step_fire;
        result.busy_res     = (steps_next != '0);
        result.rejected     = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg   <= '0;
            forward_reg <= 1'b0;
            pos_reg     <= '0;
            elapsed_reg <= '0;
            coil_reg    <= '0;
        end
        else
        begin
            steps_reg   <= steps_next;
            forward_reg <= forward_next;
            pos_reg     <= pos_next;
            elapsed_reg <= elapsed_next;
            coil_reg    <= coil_next;
        end
    end

    `SMSEQ_ASSERT_NEXT(a_step_counts_down, step_fire,
        steps_reg == $past(steps_reg) - COUNT_WIDTH'(1), "step did not consume a count")
    `SMSEQ_ASSERT_IMPL(a_reject_only_busy, rejected,
        busy && (steps_next == steps_reg), "move rejected while idle or altered count")
    `SMSEQ_ASSERT_IMPL(a_coil_matches_phase, coil_reg != '0,
        coil_reg == coil_for_phase(pos_reg[1:0]), "coil pattern out of step with position")

endmodule

// ----- rtl/core/smseq_out_queue.sv -----
// Two-entry result queue parting the step core from the result channel
`include "stepper_move_sequencer_unit_defines.svh"
module smseq_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  smseq_pkg::out_item_t  push_item,
    output logic                  has_room,
    smseq_out_if.source           out_ch
);
    import smseq_pkg::*;

    out_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    always_comb
    begin
        pop         = out_ch.valid && out_ch.ready;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign has_room       = (count_reg != 2'd2);
    assign out_ch.valid   = (count_reg != 2'd0);
    assign out_ch.payload = entry_reg[rd_ptr_reg];

    `SMSEQ_ASSERT(a_count_bound, count_reg <= 2'd2, "result queue overfilled")
    `SMSEQ_ASSERT_IMPL(a_no_push_when_full, count_reg == 2'd2, !push,
        "result pushed into a full queue")
    `SMSEQ_ASSERT(a_ptrs_track_count,
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg), "queue pointers disagree with count")

endmodule

// ----- rtl/core/stepper_move_sequencer_unit.sv -----
// Top level: full-step sequencer for a four-wire stepper motor
//
//  channel    dir  handshake      payload
//  in_ch      in   valid/ready    opcode, move_steps
//  out_ch     out  valid/ready    coil_pattern, position, stepped, busy_res, rejected
//  cfg        in   cfg_we         cfg_index, cfg_data (no read-back)
//
// One item per cycle while the queue has room: each transfer on in_ch is
// resolved in the cycle it is taken, one compare and one increment in the
// step core, result registered into a two-entry queue.
// in_ch.ready falls only when both queue entries are waiting on out_ch.
// Reset restores the interval to 183, the revolution to 2048, all else zero but the queue entries.
module stepper_move_sequencer_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    smseq_in_if.sink                            in_ch,
    smseq_out_if.source                         out_ch,
    input  logic                                cfg_we,
    input  smseq_pkg::cfg_index_t               cfg_index,
    input  logic [smseq_pkg::INTERVAL_W-1:0]    cfg_data
);
    import smseq_pkg::*;

    cfg_t      cfg;
    out_item_t result;
    logic      has_room;
    logic      accept;

    assign in_ch.ready = has_room;
    assign accept      = in_ch.valid && has_room;

    smseq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smseq_step_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (in_ch.payload),
        .result (result)
    );

    smseq_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (result),
        .has_room  (has_room),
        .out_ch    (out_ch)
    );

endmodule

// ----- test/stepper_move_sequencer_unit_tb.sv -----
// Testbench for stepper_move_sequencer_unit: random and directed items against a predictor
module stepper_move_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smseq_pkg::*;

    localparam int COUNT_W = 16;
    localparam logic [16:0] COUNT_MAX = (17'd1 << COUNT_W) - 17'd1;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic [POS_W-1:0]      rev;
        logic [COUNT_W-1:0]    remaining;
        logic                  forward;
        logic [POS_W-1:0]      pos;
        logic [INTERVAL_W-1:0] elapsed;
        logic [COIL_W-1:0]     coil;
    } motor_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = CFG_STEP_INTERVAL;
    logic [INTERVAL_W-1:0] cfg_data = '0;

    smseq_in_if  in_ch ();
    smseq_out_if out_ch ();

    stepper_move_sequencer_unit #(.COUNT_WIDTH(COUNT_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    motor_t      motor;
    in_item_t    item_backlog[$];
    out_item_t   predicted_out[$];
    int unsigned mismatches = 0;
    bit          feed_gaps_on = 1'b1;
    bit          drain_stalls_on = 1'b1;
    int unsigned feed_gap_left = 0;
    int unsigned drain_stall_left = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic out_item_t advance_motor(inout motor_t m, input in_item_t it);
        out_item_t   res;
        logic [16:0] mag;
        res = '0;
        if (it.opcode == OP_MOVE)
        begin
            if (m.remaining != '0)
                res.rejected = 1'b1;
            else if (it.move_steps != '0)
            begin
                if (it.move_steps[MOVE_W-1])
                begin
                    mag = 17'h10000 - {1'b0, it.move_steps};
                    m.forward = 1'b0;
                end
                else
                begin
                    mag = {1'b0, it.move_steps};
                    m.forward = 1'b1;
                end
                if (mag > COUNT_MAX)
                    mag = COUNT_MAX;
                m.remaining = mag[COUNT_W-1:0];
            end
        end
        else if (m.remaining != '0)
        begin
            if (m.elapsed != TICK_MAX)
                m.elapsed = m.elapsed + 1'b1;
            if (m.elapsed >= m.interval)
            begin
                m.elapsed = '0;
                if (m.forward)
                begin
                    if (m.pos >= m.rev)
                        m.pos = '0;
                    m.pos = m.pos + 1'b1;
                end
                else
                begin
                    if (m.pos == '0 || m.pos > m.rev)
                        m.pos = m.rev;
                    m.pos = m.pos - 1'b1;
                end
                case (m.pos[1:0])
                    2'd0:    m.coil = COIL_PHASE0;
                    2'd1:    m.coil = COIL_PHASE1;
                    2'd2:    m.coil = COIL_PHASE2;
                    default: m.coil = COIL_PHASE3;
                endcase
                m.remaining = m.remaining - 1'b1;
                res.stepped = 1'b1;
            end
        end
        res.coil_pattern = m.coil;
        res.position = m.pos;
        res.busy_res = (m.remaining != '0);
        return res;
    endfunction

    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_item(input opcode_t op, input logic [MOVE_W-1:0] steps);
        in_item_t it;
        it.opcode = op;
        it.move_steps = steps;
        item_backlog.push_back(it);
    endtask

    task automatic drain();
        while (item_backlog.size() != 0 || in_ch.valid || predicted_out.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [INTERVAL_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_STEP_INTERVAL)
            motor.interval = val;
        else
            motor.rev = val[POS_W-1:0];
    endtask

    task automatic set_motor(input logic [INTERVAL_W-1:0] interval, input logic [POS_W-1:0] rev);
        drain();
        write_reg(CFG_STEP_INTERVAL, interval);
        write_reg(CFG_STEPS_PER_REV, {{(INTERVAL_W-POS_W){1'b0}}, rev});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // source side: one transfer per accepted item, prediction taken at acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predicted_out.push_back(advance_motor(motor, in_ch.payload));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (feed_gap_left != 0)
                begin
                    feed_gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (item_backlog.size() != 0)
                begin
                    in_ch.payload <= item_backlog.pop_front();
                    in_ch.valid <= 1'b1;
                    feed_gap_left = pick_gap(feed_gaps_on);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                if (predicted_out.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %p", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = predicted_out.pop_front();
                    compare_field("coil_pattern", 32'(want.coil_pattern),
                                  32'(got.coil_pattern));
                    compare_field("position", 32'(want.position), 32'(got.position));
                    compare_field("stepped", 32'(want.stepped), 32'(got.stepped));
                    compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                    compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
                end
            end
            if (drain_stall_left != 0)
            begin
                drain_stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                drain_stall_left = pick_gap(drain_stalls_on);
            end
        end
    end

    initial
    begin
        motor_t                plan;
        logic [MOVE_W-1:0]     steps;
        int unsigned           r;
        int unsigned           mag;
        logic [INTERVAL_W-1:0] interval;
        logic [POS_W-1:0]      rev;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        motor = '0;
        motor.interval = INTERVAL_RESET;
        motor.rev = REV_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: idle tick, zero move, rejection of both extremes, counter builds up
        queue_item(OP_TICK, 16'h1234);
        queue_item(OP_MOVE, 16'h0000);
        queue_item(OP_MOVE, 16'h0002);
        queue_item(OP_MOVE, 16'h8000);
        queue_item(OP_MOVE, 16'h7FFF);
        queue_item(OP_TICK, 16'hFFFF);
        queue_item(OP_TICK, 16'h0000);

        // interval lowered below the elapsed count, then backward wrap through zero
        set_motor(24'd2, 16'd4);
        repeat (3) queue_item(OP_TICK, 16'h0000);
        queue_item(OP_MOVE, 16'hFFFD);
        repeat (6) queue_item(OP_TICK, 16'h5A5A);

        // zero revolution
        set_motor(24'd0, 16'd0);
        queue_item(OP_MOVE, 16'h0001);
        queue_item(OP_TICK, 16'h0000);
        queue_item(OP_MOVE, 16'hFFFF);
        queue_item(OP_TICK, 16'h0000);

        // position above the revolution
        set_motor(24'd1, 16'd4);
        queue_item(OP_MOVE, 16'hFFFF);
        queue_item(OP_TICK, 16'h0000);
        queue_item(OP_MOVE, 16'h0001);
        queue_item(OP_TICK, 16'h0000);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_motor(24'd1, 16'hFFFF);
                1: set_motor(24'hFF_FFFF, 16'd4);
                default:
                begin
                    r = $urandom_range(0, 9);
                    interval = (r == 0) ? 24'd0 : (r == 1) ? 24'd1 :
                               (r == 2) ? 24'hFF_FFFF :
                               (r == 3) ? 24'($urandom_range(7, 300)) :
                               24'($urandom_range(2, 6));
                    r = $urandom_range(0, 9);
                    rev = (r == 0) ? 16'd4 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd2048 :
                          (r == 3) ? 16'($urandom_range(4, 65535)) :
                          16'($urandom_range(4, 12));
                    set_motor(interval, rev);
                end
            endcase
            feed_gaps_on = ($urandom_range(0, 3) != 0);
            drain_stalls_on = ($urandom_range(0, 3) != 0);
            plan = motor;
            repeat (105)
            begin
                r = $urandom_range(0, 99);
                if (plan.remaining == '0)
                begin
                    if (r < 65)
                    begin
                        mag = (r < 3) ? $urandom_range(13, 64) : $urandom_range(1, 12);
                        steps = 16'(mag);
                        if ($urandom_range(0, 1))
                            steps = -steps;
                        queue_item(OP_MOVE, steps);
                    end
                    else if (r < 75)
                        queue_item(OP_MOVE, 16'h0000);
                    else
                        queue_item(OP_TICK, 16'($urandom_range(0, 65535)));
                end
                else if (r < 85)
                    queue_item(OP_TICK, 16'($urandom_range(0, 65535)));
                else
                    queue_item(OP_MOVE, 16'($urandom_range(0, 65535)));
                void'(advance_motor(plan, item_backlog[$]));
            end
        end

        // finish any move left over, then most negative move taken, back to back
        set_motor(24'd0, 16'hFFFF);
        feed_gaps_on = 1'b0;
        drain_stalls_on = 1'b0;
        repeat (motor.remaining) queue_item(OP_TICK, 16'h0000);
        queue_item(OP_MOVE, 16'h8000);
        repeat (40) queue_item(OP_TICK, 16'($urandom_range(0, 65535)));

        drain();
        repeat (5) @(negedge clk);
        if (mismatches == 0)
            $display("stepper_move_sequencer_unit_tb: done, clean");
        else
            $display("stepper_move_sequencer_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("stepper_move_sequencer_unit_tb: done, errors");
        $finish;
    end

endmodule
